FILE: hw/rtl/calendar_to_epoch_seconds_assert.svh
// ----------------------------------------------------------------------------
// Calendar to epoch seconds: assertion macros
// Shared concurrent-assertion forms for the conversion pipeline.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH
`define CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH

// same-cycle implication, disabled in reset
`define C2ES_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define C2ES_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/c2es_pkg.sv
// ----------------------------------------------------------------------------
// Calendar to epoch seconds: package
// Register indexes, field widths and month tables.
// ----------------------------------------------------------------------------
`default_nettype none

package c2es_pkg;

   localparam int unsigned ZoneW  = 17;
   localparam int unsigned YearW  = 7;
   localparam int unsigned MonthW = 4;
   localparam int unsigned DayW   = 5;
   localparam int unsigned HourW  = 5;
   localparam int unsigned MinW   = 6;
   localparam int unsigned SecW   = 6;
   localparam int unsigned EpochW = 33;
   localparam int unsigned CsrIdxW = 2;

   localparam int unsigned ReqDataW = 40;
   localparam int unsigned RspDataW = 40;

   localparam logic [CsrIdxW-1:0] REG_ZONE_OFFSET = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_MIN_YEAR    = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_MAX_YEAR    = 2'd2;

   localparam logic [ZoneW-1:0] ZONE_RESET     = '0;
   localparam logic [YearW-1:0] MIN_YEAR_RESET = 7'd70;
   localparam logic [YearW-1:0] MAX_YEAR_RESET = 7'd99;

   typedef logic [MonthW-1:0] month_type;

   // days before the first of the month; invalid high months count a full year
   function automatic logic [8:0] month_start(input month_type m);
      logic [8:0] d;
      case (m)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd365;
      endcase
      return d;
   endfunction

   // days in the month, zero for an invalid month
   function automatic logic [4:0] month_length(input month_type m, input logic leap);
      logic [4:0] d;
      case (m)
         4'd2:                      d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:        d = 5'd31;
         default:                   d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/calendar_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// Calendar to epoch seconds
// Converts a two-digit-year calendar stamp into seconds since 1970 plus a
// configured zone offset, and flags whether every field is in range.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle when the response side does not stall;
// three register stages (input, day count, result), each with its own
// valid, so stalls only back up full stages.
// Reset: synchronous active-high; clears all stage valids and loads the zone
// offset (0), min_year (70) and max_year (99).
`default_nettype none

module calendar_to_epoch_seconds (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   // month[3:0], day_of_month[8:4], year_in_century[15:9], hour[20:16],
   // minute[26:21], second[32:27], zero fill above
   input  wire logic [c2es_pkg::ReqDataW-1:0] req_tdata,
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   // epoch_seconds[32:0], zero fill above
   output      logic [c2es_pkg::RspDataW-1:0] rsp_tdata,
   // fields_valid[0]
   output      logic                          rsp_tuser,
   input  wire logic                          csr_we,
   input  wire logic [c2es_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [c2es_pkg::ZoneW-1:0]    csr_wdata
);
   import c2es_pkg::*;

   `include "calendar_to_epoch_seconds_assert.svh"

   logic [ZoneW-1:0]  zone_ff;
   logic [YearW-1:0]  min_year_ff;
   logic [YearW-1:0]  max_year_ff;

   logic              in_vld_ff, in_vld_in;
   logic [MonthW-1:0] in_month_ff;
   logic [DayW-1:0]   in_day_ff;
   logic [YearW-1:0]  in_year_ff;
   logic [HourW-1:0]  in_hour_ff;
   logic [MinW-1:0]   in_min_ff;
   logic [SecW-1:0]   in_sec_ff;

   logic              s1_vld_ff, s1_vld_in;
   logic [15:0]       s1_days_ff, s1_days_in;
   logic [16:0]       s1_tod_ff, s1_tod_in;
   logic              s1_ok_ff, s1_ok_in;

   logic              out_vld_ff, out_vld_in;
   logic [EpochW-1:0] out_epoch_ff, out_epoch_in;
   logic              out_ok_ff;

   logic              out_rdy, s1_rdy, in_rdy;
   logic              req_acc, s1_load, out_load;

   logic              leap;
   logic [14:0]       yr_ext;
   logic [14:0]       yr_days;
   logic [4:0]        max_day;
   logic [33:0]       secs;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff     <= ZONE_RESET;
         min_year_ff <= MIN_YEAR_RESET;
         max_year_ff <= MAX_YEAR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_ZONE_OFFSET: zone_ff     <= csr_wdata;
            REG_MIN_YEAR:    min_year_ff <= csr_wdata[YearW-1:0];
            REG_MAX_YEAR:    max_year_ff <= csr_wdata[YearW-1:0];
            default: ;
         endcase
      end
   end

   // flow control: a stage advances when empty or when the next one advances
   assign out_rdy    = !out_vld_ff || rsp_tready;
   assign s1_rdy     = !s1_vld_ff || out_rdy;
   assign in_rdy     = !in_vld_ff || s1_rdy;
   assign req_tready = in_rdy;
   assign req_acc    = req_tvalid && in_rdy;
   assign s1_load    = in_vld_ff && s1_rdy;
   assign out_load   = s1_vld_ff && out_rdy;

   always_comb begin
      in_vld_in  = in_rdy  ? req_tvalid : in_vld_ff;
      s1_vld_in  = s1_rdy  ? in_vld_ff  : s1_vld_ff;
      out_vld_in = out_rdy ? s1_vld_ff  : out_vld_ff;
   end

   // stage 1: day count, time of day, range checks
   always_comb begin
      leap    = (in_year_ff[1:0] == 2'b00);
      yr_ext  = {8'd0, in_year_ff};
      // (yr - 70) * 365 + leap days since 1970, valid for yr above 70
      yr_days = (in_year_ff > 7'd70)
              ? (yr_ext * 15'd365) - 15'd25550 + ((yr_ext + 15'd3) >> 2) - 15'd18
              : 15'd0;
      s1_days_in = {1'b0, yr_days}
                 + {7'd0, month_start(in_month_ff)}
                 + {15'd0, (leap && (in_month_ff > 4'd2))}
                 + {11'd0, in_day_ff}
                 - 16'd1;
      s1_tod_in  = ({12'd0, in_hour_ff} * 17'd3600)
                 + ({11'd0, in_min_ff} * 17'd60)
                 + {11'd0, in_sec_ff};
      max_day    = month_length(in_month_ff, leap);
      s1_ok_in   = (in_month_ff >= 4'd1) && (in_month_ff <= 4'd12)
                && (in_day_ff >= 5'd1) && (in_day_ff <= max_day)
                && (in_year_ff >= min_year_ff) && (in_year_ff <= max_year_ff)
                && (in_hour_ff < 5'd24) && (in_min_ff < 6'd60) && (in_sec_ff < 6'd60);
   end

   // stage 2: scale days to seconds, add time of day and zone offset
   always_comb begin
      secs = ($signed({{18{s1_days_ff[15]}}, s1_days_ff}) * $signed(34'sd86400))
           + $signed({17'd0, s1_tod_ff})
           + $signed({{17{zone_ff[ZoneW-1]}}, zone_ff});
      out_epoch_in = secs[EpochW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_month_ff <= req_tdata[3:0];
         in_day_ff   <= req_tdata[8:4];
         in_year_ff  <= req_tdata[15:9];
         in_hour_ff  <= req_tdata[20:16];
         in_min_ff   <= req_tdata[26:21];
         in_sec_ff   <= req_tdata[32:27];
      end
      if (s1_load) begin
         s1_days_ff <= s1_days_in;
         s1_tod_ff  <= s1_tod_in;
         s1_ok_ff   <= s1_ok_in;
      end
      if (out_load) begin
         out_epoch_ff <= out_epoch_in;
         out_ok_ff    <= s1_ok_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RspDataW-EpochW){1'b0}}, out_epoch_ff};
   assign rsp_tuser  = out_ok_ff;

   `C2ES_ASSERT_NEXT(a_req_enters_input, clock, reset, req_acc, in_vld_ff,
      "accepted request beat not held in input stage")
   `C2ES_ASSERT_NOW(a_ok_days_nonneg, clock, reset, s1_vld_ff && s1_ok_ff,
      !s1_days_ff[15], "valid stamp with negative day count")
   `C2ES_ASSERT_NOW(a_ok_tod_range, clock, reset, s1_vld_ff && s1_ok_ff,
      s1_tod_ff < 17'd86400, "valid stamp with time of day past one day")
   `C2ES_ASSERT_NOW(a_full_pipe_stalls, clock, reset,
      out_vld_ff && !rsp_tready && s1_vld_ff && in_vld_ff, !req_tready,
      "request taken while every stage is full and stalled")

endmodule

`default_nettype wire
